>>> sv/bfms_pkg.sv
package bfms_pkg;

   localparam int PROG_DEPTH_DEF = 4096;
   localparam int TAPE_DEPTH_DEF = 4096;

   localparam int OP_W        = 2;
   localparam int PROG_ADDR_W = 12;
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int TAPE_SIZE_W = 13;

   localparam logic [TAPE_SIZE_W-1:0] TAPE_SIZE_RESET = 13'd4096;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [STATUS_W-1:0] ST_RUN     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_HALT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OOM     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BRACKET = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [PROG_ADDR_W-1:0] prog_addr;
      logic [BYTE_W-1:0]      prog_char;
      logic [BYTE_W-1:0]      in_byte;
   } req_type;

   typedef struct packed {
      logic                out_valid;
      logic [BYTE_W-1:0]   out_byte;
      logic                input_used;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_start;
      logic scan_done;
      logic rsp_free;
   } stat_type;

endpackage

>>> sv/bfms_ram.sv
module bfms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bfms_ctrl.sv
module bfms_ctrl
   import bfms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.scan_start ? S_SCAN : S_RESULT;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

>>> sv/bfms_dpath.sv
module bfms_dpath
   import bfms_pkg::*;
#(
   parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
   parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TAPE_SIZE_W-1:0] csr_data
);

   localparam int PA_W      = $clog2(PROG_DEPTH);
   localparam int PC_W      = $clog2(PROG_DEPTH + 1);
   localparam int DP_W      = $clog2(TAPE_DEPTH);
   localparam int FILL_W    = $clog2(TAPE_DEPTH + 1);
   localparam int LIM_W     = (FILL_W > TAPE_SIZE_W) ? FILL_W : TAPE_SIZE_W;
   localparam int DEPTH_W   = PC_W + 1;
   localparam int MOD_STEPS = $clog2(((1 << PROG_ADDR_W) - 1) / PROG_DEPTH + 1);
   localparam int MOD_BASE  = (PC_W + MOD_STEPS > PROG_ADDR_W) ? PC_W + MOD_STEPS : PROG_ADDR_W;
   localparam int MOD_W     = MOD_BASE + 1;

   localparam logic [BYTE_W-1:0] CH_END   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

   localparam logic [PC_W-1:0]  PC_END    = PC_W'(PROG_DEPTH);
   localparam logic [PA_W-1:0]  ADDR_LAST = PA_W'(PROG_DEPTH - 1);
   localparam logic [LIM_W-1:0] TAPE_LIM  = LIM_W'(TAPE_DEPTH);

   function automatic logic [PA_W-1:0] store_addr(input logic [PROG_ADDR_W-1:0] a);
      logic [MOD_W-1:0] r;
      r = MOD_W'(a);
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (r >= (MOD_W'(PROG_DEPTH) << k)) begin
            r = r - (MOD_W'(PROG_DEPTH) << k);
         end
      end
      return r[PA_W-1:0];
   endfunction

   req_type                 req_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;
   logic [TAPE_SIZE_W-1:0]  tape_size_ff;

   logic [PC_W-1:0]     pc_ff, pc_in;
   logic [DP_W-1:0]     dp_ff, dp_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [STATUS_W-1:0] run_ff, run_in;
   logic [PA_W-1:0]     scan_ff, scan_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic                fwd_ff, fwd_in;
   logic                outv_ff, outv_in;
   logic [BYTE_W-1:0]   outb_ff, outb_in;
   logic                used_ff, used_in;

   logic [BYTE_W-1:0]  prog_rdata, tape_rdata, tape_wdata, cell_val;
   logic               prog_we, tape_we, scan_go;
   logic [PA_W-1:0]    prog_raddr, pc_rd;
   logic [LIM_W-1:0]   lim, dp_ext;
   logic [DEPTH_W-1:0] depth_nx;
   logic               dp_at_fill;

   assign lim        = (LIM_W'(tape_size_ff) < TAPE_LIM) ? LIM_W'(tape_size_ff) : TAPE_LIM;
   assign dp_ext     = LIM_W'(dp_ff);
   assign dp_at_fill = (FILL_W'(dp_ff) == fill_ff);
   assign cell_val   = dp_at_fill ? '0 : tape_rdata;
   assign pc_rd      = (pc_ff < PC_END) ? pc_ff[PA_W-1:0] : '0;

   always_comb begin
      pc_in      = pc_ff;
      dp_in      = dp_ff;
      fill_in    = fill_ff;
      run_in     = run_ff;
      scan_in    = scan_ff;
      depth_in   = depth_ff;
      fwd_in     = fwd_ff;
      outv_in    = outv_ff;
      outb_in    = outb_ff;
      used_in    = used_ff;
      prog_we    = 1'b0;
      tape_we    = 1'b0;
      tape_wdata = '0;
      scan_go    = 1'b0;
      depth_nx   = depth_ff;
      stat       = '0;

      if (cmd.exec) begin
         outv_in = 1'b0;
         outb_in = '0;
         used_in = 1'b0;
         unique case (req_ff.op)
            OP_LOAD: begin
               prog_we = 1'b1;
            end
            OP_RESTART: begin
               pc_in   = '0;
               dp_in   = '0;
               fill_in = '0;
               run_in  = ST_RUN;
            end
            OP_STEP: begin
               if (run_ff == ST_RUN) begin
                  if (dp_ext >= lim) begin
                     run_in = ST_OOM;
                  end else if (pc_ff == PC_END) begin
                     run_in = ST_HALT;
                  end else begin
                     pc_in = pc_ff + PC_W'(1);
                     unique case (prog_rdata)
                        CH_END: begin
                           run_in = ST_HALT;
                           pc_in  = pc_ff;
                        end
                        CH_RIGHT: begin
                           if (dp_ext + LIM_W'(1) >= lim) begin
                              run_in = ST_OOM;
                              pc_in  = pc_ff;
                           end else begin
                              dp_in = dp_ff + DP_W'(1);
                              if (dp_at_fill) begin
                                 tape_we = 1'b1;
                                 fill_in = fill_ff + FILL_W'(1);
                              end
                           end
                        end
                        CH_LEFT: begin
                           if (dp_ff == '0) begin
                              run_in = ST_OOM;
                              pc_in  = pc_ff;
                           end else begin
                              dp_in = dp_ff - DP_W'(1);
                           end
                        end
                        CH_INC, CH_DEC, CH_IN: begin
                           tape_we = 1'b1;
                           if (prog_rdata == CH_INC) begin
                              tape_wdata = cell_val + 8'd1;
                           end else if (prog_rdata == CH_DEC) begin
                              tape_wdata = cell_val - 8'd1;
                           end else begin
                              tape_wdata = req_ff.in_byte;
                              used_in    = 1'b1;
                           end
                           if (dp_at_fill) begin
                              fill_in = fill_ff + FILL_W'(1);
                           end
                        end
                        CH_OUT: begin
                           outv_in = 1'b1;
                           outb_in = cell_val;
                        end
                        CH_OPEN: begin
                           if (cell_val == '0) begin
                              pc_in = pc_ff;
                              if (pc_ff[PA_W-1:0] == ADDR_LAST) begin
                                 run_in = ST_BRACKET;
                              end else begin
                                 stat.scan_start = 1'b1;
                                 scan_go  = 1'b1;
                                 scan_in  = pc_ff[PA_W-1:0] + PA_W'(1);
                                 depth_in = DEPTH_W'(1);
                                 fwd_in   = 1'b1;
                              end
                           end
                        end
                        CH_CLOSE: begin
                           if (cell_val != '0) begin
                              pc_in = pc_ff;
                              if (pc_ff == '0) begin
                                 run_in = ST_BRACKET;
                              end else begin
                                 stat.scan_start = 1'b1;
                                 scan_go  = 1'b1;
                                 scan_in  = pc_ff[PA_W-1:0] - PA_W'(1);
                                 depth_in = DEPTH_W'(1);
                                 fwd_in   = 1'b0;
                              end
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan) begin
         if (fwd_ff) begin
            depth_nx = depth_ff + DEPTH_W'(prog_rdata == CH_OPEN)
                                - DEPTH_W'(prog_rdata == CH_CLOSE);
         end else begin
            depth_nx = depth_ff + DEPTH_W'(prog_rdata == CH_CLOSE)
                                - DEPTH_W'(prog_rdata == CH_OPEN);
         end
         priority if (fwd_ff && prog_rdata == CH_END) begin
            run_in         = ST_BRACKET;
            stat.scan_done = 1'b1;
         end else if (depth_nx == '0) begin
            pc_in          = PC_W'(scan_ff) + PC_W'(1);
            stat.scan_done = 1'b1;
         end else if (fwd_ff && scan_ff == ADDR_LAST) begin
            run_in         = ST_BRACKET;
            stat.scan_done = 1'b1;
         end else if (!fwd_ff && scan_ff == '0) begin
            run_in         = ST_BRACKET;
            stat.scan_done = 1'b1;
         end else begin
            scan_go  = 1'b1;
            depth_in = depth_nx;
            scan_in  = fwd_ff ? scan_ff + PA_W'(1) : scan_ff - PA_W'(1);
         end
      end

      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign prog_raddr = scan_go ? scan_in : pc_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         dp_ff        <= '0;
         fill_ff      <= '0;
         run_ff       <= ST_RUN;
         tape_size_ff <= TAPE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         dp_ff   <= dp_in;
         fill_ff <= fill_in;
         run_ff  <= run_in;
         if (csr_valid) begin
            tape_size_ff <= csr_data;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      depth_ff <= depth_in;
      fwd_ff   <= fwd_in;
      outv_ff  <= outv_in;
      outb_ff  <= outb_in;
      used_ff  <= used_in;
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff.out_valid  <= outv_ff;
         rsp_ff.out_byte   <= outb_ff;
         rsp_ff.input_used <= used_ff;
         rsp_ff.status     <= run_ff;
      end
   end

   bfms_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(PROG_DEPTH)
   ) u_prog_ram (
      .clock  (clock),
      .wr_en  (prog_we),
      .wr_addr(store_addr(req_ff.prog_addr)),
      .wr_data(req_ff.prog_char),
      .rd_addr(prog_raddr),
      .rd_data(prog_rdata)
   );

   bfms_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(TAPE_DEPTH)
   ) u_tape_ram (
      .clock  (clock),
      .wr_en  (tape_we),
      .wr_addr(dp_ff),
      .wr_data(tape_wdata),
      .rd_addr(dp_ff),
      .rd_data(tape_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_dp_within_fill: assert property (@(posedge clock) disable iff (reset)
      LIM_W'(dp_ff) <= LIM_W'(fill_ff))
      else $error("data pointer beyond tape fill count");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_END)
      else $error("program counter beyond end of store");

   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      (run_ff != ST_RUN && !(cmd.exec && req_ff.op == OP_RESTART))
      |=> ($stable(pc_ff) && $stable(dp_ff) && $stable(fill_ff)))
      else $error("stopped machine moved its pointers");

   a_scan_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (depth_ff != '0))
      else $error("bracket scan running with zero depth");

endmodule

>>> sv/brainfuck_machine_step_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_data (req_type)
// rsp       out        rsp_valid/rsp_stall  rsp_data (rsp_type)
// csr       in         csr_valid/csr_ready  csr_data (tape_size)
//
// A request passes through EXEC, then SCAN while a taken bracket is scanned (one
// program store read a cycle), then RESULT, which waits for a free response
// register; rsp_valid rises as the controller returns to IDLE for the next request.
// Reset is synchronous; tape cells past a fill count read as zero, so neither
// reset nor restart sweeps the tape.
// rsp_stall holds the result; the next request is accepted while it waits.
// csr_ready is always high; a write takes effect on the next cycle.
module brainfuck_machine_step_unit
   import bfms_pkg::*;
#(
   parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
   parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TAPE_SIZE_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   bfms_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   bfms_dpath #(
      .TAPE_DEPTH(TAPE_DEPTH),
      .PROG_DEPTH(PROG_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

endmodule
